[rtl/tepq_pkg.sv]
// Package with the entry layout, sizes and ordering function of the event queue.
`timescale 1ns / 1ps
`default_nettype none
package tepq_pkg;
    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS = 32;
    localparam int TAG_BITS = 16;
    localparam int SEQ_BITS = 32;
    localparam int ADDR_BITS = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [TIME_BITS-1:0] time_v;
        logic [TAG_BITS-1:0] tag;
        logic [SEQ_BITS-1:0] seq;
    } entry_t;

    typedef struct packed {
        logic en;
        logic [ADDR_BITS-1:0] addr;
        entry_t data;
    } wr_t;

    // True when entry a leaves before entry b: smaller time, then greater age.
    function automatic logic comes_first(entry_t a, entry_t b, logic [SEQ_BITS-1:0] next_seq);
        logic [SEQ_BITS-1:0] age_a;
        logic [SEQ_BITS-1:0] age_b;
        age_a = next_seq - a.seq;
        age_b = next_seq - b.seq;
        if (a.time_v != b.time_v)
            return a.time_v < b.time_v;
        return age_a > age_b;
    endfunction
endpackage
`default_nettype wire

[rtl/tepq_store.sv]
// Entry memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tepq_store
    import tepq_pkg::*;
(
    input  wire logic                 clk,
    input  wire wr_t                  wr,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output entry_t                    rdata
);
    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/timed_event_priority_queue_core.sv]
// Top level of the timed event queue: control sequencer around the entry memory.
`timescale 1ns / 1ps
`default_nettype none
// Usage: drive kind, event_time and event_tag and raise start; the command
// transfers at a rising edge with start high and busy low.
// An insert (kind 0) writes the next free memory slot at the transfer edge;
// busy stays low. An insert to a full queue is lost and sets the sticky
// dropped flag.
// A pop (kind 1) on an empty queue gives its result in the next cycle.
// A pop on a queue of N events scans the memory one entry per cycle through
// its single read port, then reads the last entry and moves it into the
// freed slot; busy is high during the scan and the move.
// Each result is shown for one cycle with result_valid high; the receiver
// cannot stall, so the result is simply presented once.
// Reset clears the count, sequence number, current time and dropped flag;
// memory contents are left as they are and only live slots are read.
module timed_event_priority_queue_core
    import tepq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 kind,
    input  wire logic [TIME_BITS-1:0] event_time,
    input  wire logic [TAG_BITS-1:0]  event_tag,
    output logic                      result_valid,
    output logic [TIME_BITS-1:0]      out_time,
    output logic [TAG_BITS-1:0]       out_tag,
    output logic                      was_empty,
    output logic                      dropped
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_LAST = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SEQ_BITS-1:0] seq_reg, seq_next;
    logic [TIME_BITS-1:0] cur_time_reg, cur_time_next;
    logic overflow_reg, overflow_next;
    logic done_reg, done_next;
    logic empty_reg, empty_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [ADDR_BITS-1:0] idx_reg, idx_next;
    logic [ADDR_BITS-1:0] best_addr_reg, best_addr_next;
    entry_t best_reg, best_next;

    wr_t wr;
    logic [ADDR_BITS-1:0] raddr;
    entry_t rdata;
    logic accept;
    logic [COUNT_BITS-1:0] idx_plus;
    logic [COUNT_BITS-1:0] count_less;

    tepq_store u_store (
        .clk  (clk),
        .wr   (wr),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign busy = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign idx_plus = {1'b0, idx_reg} + COUNT_BITS'(1);
    assign count_less = count_reg - COUNT_BITS'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        seq_next = seq_reg;
        cur_time_next = cur_time_reg;
        overflow_next = overflow_reg;
        done_next = 1'b0;
        empty_next = empty_reg;
        tag_next = tag_reg;
        idx_next = idx_reg;
        best_addr_next = best_addr_reg;
        best_next = best_reg;
        wr.en = 1'b0;
        wr.addr = count_reg[ADDR_BITS-1:0];
        wr.data.time_v = event_time;
        wr.data.tag = event_tag;
        wr.data.seq = seq_reg;
        raddr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!kind)
                    begin
                        if (count_reg == COUNT_BITS'(QUEUE_DEPTH))
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            wr.en = 1'b1;
                            count_next = count_reg + COUNT_BITS'(1);
                            seq_next = seq_reg + SEQ_BITS'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == '0 || comes_first(rdata, best_reg, seq_reg))
                begin
                    best_next = rdata;
                    best_addr_next = idx_reg;
                end
                if (idx_plus < count_reg)
                begin
                    idx_next = idx_plus[ADDR_BITS-1:0];
                    raddr = idx_plus[ADDR_BITS-1:0];
                end
                else
                begin
                    raddr = count_less[ADDR_BITS-1:0];
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                wr.en = 1'b1;
                wr.addr = best_addr_reg;
                wr.data = rdata;
                count_next = count_less;
                cur_time_next = best_reg.time_v;
                tag_next = best_reg.tag;
                empty_next = 1'b0;
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            seq_reg <= '0;
            cur_time_reg <= '0;
            overflow_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            seq_reg <= seq_next;
            cur_time_reg <= cur_time_next;
            overflow_reg <= overflow_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        empty_reg <= empty_next;
        tag_reg <= tag_next;
        idx_reg <= idx_next;
        best_addr_reg <= best_addr_next;
        best_reg <= best_next;
    end

    assign result_valid = done_reg;
    assign out_time = empty_reg ? '0 : cur_time_reg;
    assign out_tag = empty_reg ? '0 : tag_reg;
    assign was_empty = empty_reg;
    assign dropped = overflow_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(QUEUE_DEPTH))
        else $error("entry count above queue depth");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LAST |=> done_reg && !was_empty)
        else $error("pop did not produce its result");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LAST |=> count_reg == $past(count_reg) - COUNT_BITS'(1))
        else $error("pop did not remove an entry");
    a_scan_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> {1'b0, idx_reg} < count_reg)
        else $error("scan read beyond live entries");
endmodule
`default_nettype wire
